### src/ssnf_pkg.sv
// shared types, constants and glyph lookup for the seven-segment number formatter
// no dependencies

package ssnf_pkg;

  localparam int unsigned ValueW = 17;
  localparam int unsigned SegW   = 8;
  localparam int unsigned ProdW  = 35;

  localparam logic [ValueW-1:0] ErrLimit = 17'd99900;

  // reciprocal constants, floor(v * m >> k) == v / d over the whole 17-bit range
  localparam logic [ValueW:0] Recip10    = 18'd104858;  // k = 20
  localparam logic [ValueW:0] Recip100   = 18'd167773;  // k = 24
  localparam logic [ValueW:0] Recip1000  = 18'd134218;  // k = 27
  localparam logic [ValueW:0] Recip10000 = 18'd107375;  // k = 30

  localparam logic [SegW-1:0] SegPoint = 8'b1000_0000;
  localparam logic [SegW-1:0] SegBlank = 8'b0000_0000;
  localparam logic [SegW-1:0] SegE     = 8'b0111_1001;
  localparam logic [SegW-1:0] SegR     = 8'b0101_0000;
  localparam logic [SegW-1:0] SegDash  = 8'b0100_0000;

  typedef enum logic [1:0] {
    MODE_VALUE   = 2'd0,
    MODE_PERCENT = 2'd1,
    MODE_ERROR   = 2'd2,
    MODE_MEASURE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [1:0]        mode;
  } in_word_t;

  typedef struct packed {
    logic [SegW-1:0] left_segments;
    logic [SegW-1:0] middle_segments;
    logic [SegW-1:0] right_segments;
  } out_word_t;

  function automatic logic [SegW-1:0] glyph(input logic [3:0] d);
    logic [SegW-1:0] g;
    case (d)
      4'd0:    g = 8'b0011_1111;
      4'd1:    g = 8'b0000_0110;
      4'd2:    g = 8'b0101_1011;
      4'd3:    g = 8'b0100_1111;
      4'd4:    g = 8'b0110_0110;
      4'd5:    g = 8'b0110_1101;
      4'd6:    g = 8'b0111_1101;
      4'd7:    g = 8'b0000_0111;
      4'd8:    g = 8'b0111_1111;
      4'd9:    g = 8'b0110_1111;
      default: g = SegBlank;
    endcase
    return g;
  endfunction

  function automatic logic [SegW-1:0] glyph_or_blank(input logic [3:0] d);
    logic [SegW-1:0] g;
    g = (d == 4'd0) ? SegBlank : glyph(d);
    return g;
  endfunction

endpackage

### src/seven_segment_number_formatter_top.sv
// seven-segment number formatter: value in hundredths plus mode to three digit patterns
// depends on ssnf_pkg (types, reciprocal constants, glyph functions)
//
//  channel  | ports                        | payload
//  ---------+------------------------------+--------------------------------------
//  input    | in_valid, in_stall, in_word  | value (17b), mode (2b)
//  result   | out_valid, out_stall, out_word| left/middle/right segments (8b each)
//
// the accepting edge loads the input register; the result register then takes the
// digit split and glyph selection of that word when the result stage advances
// one word per cycle sustained; both stages advance together when out_stall is low
// in_stall rises only when both stages hold a word and the result side stalls
// rst_n (synchronous, active low) clears the two valid bits; payload is not reset

module seven_segment_number_formatter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ssnf_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ssnf_pkg::out_word_t out_word
);

  // pipeline control
  logic               s1_valid_r, s1_valid_nxt;
  logic               s2_valid_r, s2_valid_nxt;
  ssnf_pkg::in_word_t  s1_word_r;
  ssnf_pkg::out_word_t s2_word_r, s2_word_nxt;
  logic               adv2;
  logic               adv1;

  // result stage moves when empty or drained this cycle; input stage follows
  assign adv2     = !s2_valid_r || !out_stall;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  assign s1_valid_nxt = adv1 ? in_valid : s1_valid_r;
  assign s2_valid_nxt = adv2 ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_word_r <= in_word;
    end
    if (adv2 && s1_valid_r) begin
      s2_word_r <= s2_word_nxt;
    end
  end

  // decimal split: each quotient comes straight from the value through its own
  // reciprocal multiply, so no multiply feeds another
  logic [ssnf_pkg::ValueW-1:0] v;
  logic [ssnf_pkg::ProdW-1:0]  p1, p2, p3, p4;
  logic [13:0]                 q1;   // v / 10
  logic [10:0]                 q2;   // v / 100
  logic [7:0]                  q3;   // v / 1000
  logic [3:0]                  q4;   // v / 10000
  logic [3:0]                  d0, d1, d2, d3, d4;

  assign v  = s1_word_r.value;
  assign p1 = ssnf_pkg::ProdW'(v) * ssnf_pkg::ProdW'(ssnf_pkg::Recip10);
  assign p2 = ssnf_pkg::ProdW'(v) * ssnf_pkg::ProdW'(ssnf_pkg::Recip100);
  assign p3 = ssnf_pkg::ProdW'(v) * ssnf_pkg::ProdW'(ssnf_pkg::Recip1000);
  assign p4 = ssnf_pkg::ProdW'(v) * ssnf_pkg::ProdW'(ssnf_pkg::Recip10000);

  assign q1 = p1[33:20];
  assign q2 = p2[34:24];
  assign q3 = p3[34:27];
  assign q4 = p4[33:30];

  // remainders against ten times the next quotient (shift-add constant scale)
  logic [ssnf_pkg::ValueW-1:0] r0;
  logic [13:0]                 r1;
  logic [10:0]                 r2;
  logic [7:0]                  r3;

  assign r0 = v  - (ssnf_pkg::ValueW'(q1) * 17'd10);
  assign r1 = q1 - (14'(q2) * 14'd10);
  assign r2 = q2 - (11'(q3) * 11'd10);
  assign r3 = q3 - (8'(q4) * 8'd10);

  assign d0 = r0[3:0];
  assign d1 = r1[3:0];
  assign d2 = r2[3:0];
  assign d3 = r3[3:0];
  assign d4 = q4;

  // glyph selection
  ssnf_pkg::mode_t mode;
  logic            too_large;

  assign mode      = ssnf_pkg::mode_t'(s1_word_r.mode);
  assign too_large = (v > ssnf_pkg::ErrLimit);

  always_comb begin
    s2_word_nxt.left_segments   = ssnf_pkg::SegE;
    s2_word_nxt.middle_segments = ssnf_pkg::SegR;
    s2_word_nxt.right_segments  = ssnf_pkg::SegR;
    if (!too_large) begin
      case (mode)
        ssnf_pkg::MODE_ERROR: begin
          s2_word_nxt.left_segments   = ssnf_pkg::SegE;
          s2_word_nxt.middle_segments = ssnf_pkg::SegR;
          s2_word_nxt.right_segments  = ssnf_pkg::SegR;
        end
        ssnf_pkg::MODE_MEASURE: begin
          s2_word_nxt.left_segments   = ssnf_pkg::SegDash;
          s2_word_nxt.middle_segments = ssnf_pkg::SegDash;
          s2_word_nxt.right_segments  = ssnf_pkg::SegDash;
        end
        ssnf_pkg::MODE_PERCENT: begin
          // zeros in the top two digits blanked, units always shown, no point
          s2_word_nxt.left_segments   = ssnf_pkg::glyph_or_blank(d4);
          s2_word_nxt.middle_segments = ssnf_pkg::glyph_or_blank(d3);
          s2_word_nxt.right_segments  = ssnf_pkg::glyph(d2);
        end
        ssnf_pkg::MODE_VALUE: begin
          // window of three digits starting at the first nonzero of the top two, else at the units digit
          if (d4 != 4'd0) begin
            s2_word_nxt.left_segments   = ssnf_pkg::glyph(d4);
            s2_word_nxt.middle_segments = ssnf_pkg::glyph(d3);
            s2_word_nxt.right_segments  = ssnf_pkg::glyph(d2) | ssnf_pkg::SegPoint;
          end else if (d3 != 4'd0) begin
            s2_word_nxt.left_segments   = ssnf_pkg::glyph(d3);
            s2_word_nxt.middle_segments = ssnf_pkg::glyph(d2) | ssnf_pkg::SegPoint;
            s2_word_nxt.right_segments  = ssnf_pkg::glyph(d1);
          end else begin
            s2_word_nxt.left_segments   = ssnf_pkg::glyph(d2) | ssnf_pkg::SegPoint;
            s2_word_nxt.middle_segments = ssnf_pkg::glyph(d1);
            s2_word_nxt.right_segments  = ssnf_pkg::glyph(d0);
          end
        end
        default: begin
          s2_word_nxt.left_segments   = ssnf_pkg::SegE;
          s2_word_nxt.middle_segments = ssnf_pkg::SegR;
          s2_word_nxt.right_segments  = ssnf_pkg::SegR;
        end
      endcase
    end
  end

  assign out_valid = s2_valid_r;
  assign out_word  = s2_word_r;

  // checks

  // stall only when both stages are full and the result side stalls
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_stall))
    else $error("input stalled while pipeline has room");

  // at most one decimal point on a shown word
  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_word.left_segments[7], out_word.middle_segments[7],
                               out_word.right_segments[7]}) <= 1))
    else $error("more than one decimal point");

  // error mode word lands as Err
  a_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv2 && s1_word_r.mode == ssnf_pkg::MODE_ERROR) |=>
      (out_valid && out_word.left_segments == ssnf_pkg::SegE &&
       out_word.middle_segments == ssnf_pkg::SegR &&
       out_word.right_segments == ssnf_pkg::SegR))
    else $error("error mode did not show Err");

  // percent mode, when in range, sets no point on the units digit and never blanks it
  a_percent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv2 && s1_word_r.mode == ssnf_pkg::MODE_PERCENT && !too_large) |=>
      (out_valid && !out_word.right_segments[7] &&
       out_word.right_segments != ssnf_pkg::SegBlank))
    else $error("percent mode units digit wrong");

  // a word in the result stage waits while stalled
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for seven_segment_number_formatter_top: directed and random display words
// depends on ssnf_pkg for the word types and mode names

module tb;

  // segment patterns, bit 0 is segment a, bit 7 the decimal point
  localparam logic [7:0] PAT_POINT = 8'h80;
  localparam logic [7:0] PAT_BLANK = 8'h00;
  localparam logic [7:0] PAT_E     = 8'h79;
  localparam logic [7:0] PAT_R     = 8'h50;
  localparam logic [7:0] PAT_DASH  = 8'h40;
  // largest value still shown on three digits; anything above reads Err
  localparam int unsigned SHOW_LIMIT = 99900;
  localparam int unsigned HOLD_CYCLES = 60;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ssnf_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ssnf_pkg::out_word_t out_word;

  // results still owed by the block, oldest first
  ssnf_pkg::out_word_t expected_display[$];
  ssnf_pkg::out_word_t display_want;
  int                  error_count = 0;

  // sender burst shaping and receiver stall shaping, set per test
  int gap_max = 0;
  int stall_pct = 0;
  int burst_left = 0;
  int gap_len = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int run_left = 0;

  seven_segment_number_formatter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // generous cap, far above the slowest legal run
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // segment pattern of one decimal digit
  function automatic logic [7:0] digit_pattern(input int unsigned d);
    logic [7:0] p;
    case (d)
      0:       p = 8'h3F;
      1:       p = 8'h06;
      2:       p = 8'h5B;
      3:       p = 8'h4F;
      4:       p = 8'h66;
      5:       p = 8'h6D;
      6:       p = 8'h7D;
      7:       p = 8'h07;
      8:       p = 8'h7F;
      9:       p = 8'h6F;
      default: p = PAT_BLANK;
    endcase
    return p;
  endfunction

  // like digit_pattern but a zero digit stays dark
  function automatic logic [7:0] lead_pattern(input int unsigned d);
    logic [7:0] p;
    p = (d == 0) ? PAT_BLANK : digit_pattern(d);
    return p;
  endfunction

  // what the three digits must show for one input word
  function automatic ssnf_pkg::out_word_t predict_display(input ssnf_pkg::in_word_t w);
    ssnf_pkg::out_word_t o;
    int unsigned         rest;
    int unsigned         dig [5];
    rest = 32'(w.value);
    for (int i = 0; i < 5; i++) begin
      dig[i] = rest % 10;
      rest = rest / 10;
    end
    if (32'(w.value) > SHOW_LIMIT || w.mode == ssnf_pkg::MODE_ERROR) begin
      // too large or error mode both read "Err"
      o = {PAT_E, PAT_R, PAT_R};
    end else if (w.mode == ssnf_pkg::MODE_MEASURE) begin
      o = {PAT_DASH, PAT_DASH, PAT_DASH};
    end else if (w.mode == ssnf_pkg::MODE_PERCENT) begin
      // whole percent, zeros in the top two digits dark, no point
      o = {lead_pattern(dig[4]), lead_pattern(dig[3]), digit_pattern(dig[2])};
    end else if (dig[4] != 0) begin
      o = {digit_pattern(dig[4]), digit_pattern(dig[3]), digit_pattern(dig[2]) | PAT_POINT};
    end else if (dig[3] != 0) begin
      o = {digit_pattern(dig[3]), digit_pattern(dig[2]) | PAT_POINT, digit_pattern(dig[1])};
    end else begin
      o = {digit_pattern(dig[2]) | PAT_POINT, digit_pattern(dig[1]), digit_pattern(dig[0])};
    end
    return o;
  endfunction

  function automatic ssnf_pkg::in_word_t make_word(input int unsigned v,
                                                   input ssnf_pkg::mode_t m);
    ssnf_pkg::in_word_t w;
    w.value = v[ssnf_pkg::ValueW-1:0];
    w.mode  = m;
    return w;
  endfunction

  // values mostly in range, spread over every digit count, some near and past the limit
  function automatic ssnf_pkg::in_word_t random_word();
    int unsigned     sel;
    int unsigned     msel;
    int unsigned     v;
    ssnf_pkg::mode_t m;
    sel = $urandom_range(99, 0);
    if (sel < 10)      v = $urandom_range(99, 0);
    else if (sel < 30) v = $urandom_range(9999, 100);
    else if (sel < 65) v = $urandom_range(SHOW_LIMIT, 10000);
    else if (sel < 75) v = $urandom_range(SHOW_LIMIT + 10, SHOW_LIMIT - 10);
    else               v = $urandom_range(131071, 0);
    msel = $urandom_range(9, 0);
    if (msel < 4)      m = ssnf_pkg::MODE_VALUE;
    else if (msel < 7) m = ssnf_pkg::MODE_PERCENT;
    else if (msel < 8) m = ssnf_pkg::MODE_ERROR;
    else               m = ssnf_pkg::MODE_MEASURE;
    return make_word(v, m);
  endfunction

  // offer one word, wait for it to be taken, then maybe end the burst with a gap
  task automatic send_word(input ssnf_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_display.push_back(predict_display(w));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(15, 0);
      gap_len = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap_len != 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait until every owed result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_display.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      error_count++;
    end
  endtask

  // result side: compare every taken word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_display.size() == 0) begin
        $error("out_word %06h arrived with nothing outstanding", out_word);
        error_count++;
      end else begin
        display_want = expected_display.pop_front();
        check_field("left_segments", display_want.left_segments, out_word.left_segments);
        check_field("middle_segments", display_want.middle_segments, out_word.middle_segments);
        check_field("right_segments", display_want.right_segments, out_word.right_segments);
      end
    end
  end

  // receiver stall runs of random length, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (run_left != 0) begin
      run_left--;
    end else begin
      run_left = $urandom_range(7, 0);
      out_stall <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // value mode: point position moves with the first nonzero of the top two digits
  task automatic test_value_mode();
    gap_max = 3;
    stall_pct = 20;
    send_word(make_word(0, ssnf_pkg::MODE_VALUE));
    send_word(make_word(5, ssnf_pkg::MODE_VALUE));
    send_word(make_word(99, ssnf_pkg::MODE_VALUE));
    send_word(make_word(100, ssnf_pkg::MODE_VALUE));
    send_word(make_word(999, ssnf_pkg::MODE_VALUE));
    send_word(make_word(1000, ssnf_pkg::MODE_VALUE));
    send_word(make_word(9999, ssnf_pkg::MODE_VALUE));
    send_word(make_word(10000, ssnf_pkg::MODE_VALUE));
    send_word(make_word(99899, ssnf_pkg::MODE_VALUE));
    send_word(make_word(SHOW_LIMIT, ssnf_pkg::MODE_VALUE));
    drain_results();
  endtask

  // percent mode: zeros in the top two digits dark even when a nonzero digit follows
  task automatic test_percent_mode();
    send_word(make_word(0, ssnf_pkg::MODE_PERCENT));
    send_word(make_word(150, ssnf_pkg::MODE_PERCENT));
    send_word(make_word(1000, ssnf_pkg::MODE_PERCENT));
    send_word(make_word(10000, ssnf_pkg::MODE_PERCENT));
    send_word(make_word(SHOW_LIMIT, ssnf_pkg::MODE_PERCENT));
    drain_results();
  endtask

  // "Err" by mode or by size, and the measuring dashes
  task automatic test_error_and_dashes();
    send_word(make_word(0, ssnf_pkg::MODE_ERROR));
    send_word(make_word(131071, ssnf_pkg::MODE_ERROR));
    send_word(make_word(131071, ssnf_pkg::MODE_VALUE));
    send_word(make_word(SHOW_LIMIT + 1, ssnf_pkg::MODE_PERCENT));
    send_word(make_word(SHOW_LIMIT + 1, ssnf_pkg::MODE_MEASURE));
    send_word(make_word(0, ssnf_pkg::MODE_MEASURE));
    send_word(make_word(SHOW_LIMIT, ssnf_pkg::MODE_MEASURE));
    drain_results();
  endtask

  // receiver holds off long enough that the pipeline fills and stalls the sender
  task automatic test_backpressure();
    gap_max = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    repeat (48) send_word(random_word());
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int gaps, input int stalls);
    gap_max = gaps;
    stall_pct = stalls;
    repeat (count) send_word(random_word());
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_value_mode();
    test_percent_mode();
    test_error_and_dashes();
    test_backpressure();
    // back to back with no stalls, then sender gaps, heavy stalls, and a mix
    test_random_traffic(200, 0, 0);
    test_random_traffic(400, 10, 10);
    test_random_traffic(400, 2, 70);
    test_random_traffic(400, 6, 40);

    // let any stray result show up before judging
    repeat (10) @(posedge clk);
    if (expected_display.size() != 0) begin
      $error("%0d results never arrived", expected_display.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
